### rtl/qmon_pkg.sv
// qmon_pkg: shared constants, types and the divide-by-100 helper of the quota monitor
// used by qmon_ctrl, qmon_dp and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package qmon_pkg;

  localparam int DAY_SLOTS = 31;
  localparam int IDX_W     = (DAY_SLOTS > 1) ? $clog2(DAY_SLOTS) : 1;
  localparam int CNT_W     = $clog2(DAY_SLOTS + 2);
  localparam int KEY_W     = 27;
  localparam int CNT64_W   = 64;
  localparam int DELTA_W   = 32;
  localparam int LIMIT_W   = 56;
  localparam int MONTH_W   = 21;
  localparam int SCALE_W   = 68;

  // floor(x / 100) = (x * ceil(2^34 / 100)) >> 34 for any 27-bit x
  localparam logic [27:0] DIV100_MUL = 28'd171798692;

  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_NEAR = 2'd1,
    LVL_OVER = 2'd2
  } level_e;

  typedef struct packed {
    logic [KEY_W-1:0]   day;
    logic [CNT64_W-1:0] rx;
    logic [CNT64_W-1:0] tx;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             scan_rd;
    logic             write;
    logic             sum_rd;
    logic             grade_a;
    logic             grade_b;
    logic             grade_c;
    logic [IDX_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [MONTH_W-1:0] div100(input logic [KEY_W-1:0] x);
    logic [KEY_W+27:0] p;
    p = x * DIV100_MUL;
    return p[KEY_W+27:34];
  endfunction

endpackage
`default_nettype wire

### rtl/qmon_ram.sv
// qmon_ram: generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module qmon_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/qmon_ctrl.sv
// qmon_ctrl: sequencer of the quota monitor (scan, write back, sum, grade)
// depends on qmon_pkg
`timescale 1ns / 1ps
`default_nettype none
module qmon_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire qmon_pkg::sts_t sts_i,
  output qmon_pkg::cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_SUM   = 7'b0001000,
    S_GA    = 7'b0010000,
    S_GB    = 7'b0100000,
    S_GC    = 7'b1000000
  } state_e;

  localparam logic [qmon_pkg::CNT_W-1:0] LAST_RD = qmon_pkg::CNT_W'(qmon_pkg::DAY_SLOTS - 1);
  localparam logic [qmon_pkg::CNT_W-1:0] SCAN_END = qmon_pkg::CNT_W'(qmon_pkg::DAY_SLOTS);
  localparam logic [qmon_pkg::CNT_W-1:0] SUM_END = qmon_pkg::CNT_W'(qmon_pkg::DAY_SLOTS + 1);

  state_e                      state_q, state_d;
  logic [qmon_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.addr = cnt_q[qmon_pkg::IDX_W-1:0];
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = (cnt_q <= LAST_RD);
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SCAN_END) begin
          cnt_d   = '0;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_rd = (cnt_q <= LAST_RD);
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == SUM_END) begin
          cnt_d   = '0;
          state_d = S_GA;
        end
      end
      S_GA: begin
        cmd_o.grade_a = 1'b1;
        state_d       = S_GB;
      end
      S_GB: begin
        cmd_o.grade_b = 1'b1;
        state_d       = S_GC;
      end
      S_GC: begin
        if (sts_i.out_free) begin
          cmd_o.grade_c = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN))
    else $error("accepted item did not start a scan");

  a_result_into_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.grade_c |-> sts_i.out_free)
    else $error("result loaded over a waiting result");

endmodule
`default_nettype wire

### rtl/qmon_dp.sv
// qmon_dp: datapath of the quota monitor: day table, scan trackers, sums, grading, result register
// depends on qmon_pkg and qmon_ram
`timescale 1ns / 1ps
`default_nettype none
module qmon_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire qmon_pkg::cmd_t                       cmd_i,
  output qmon_pkg::sts_t                            sts_o,
  input  wire logic [qmon_pkg::KEY_W-1:0]           day_key_i,
  input  wire logic [qmon_pkg::DELTA_W-1:0]         rx_bytes_i,
  input  wire logic [qmon_pkg::DELTA_W-1:0]         tx_bytes_i,
  input  wire logic [qmon_pkg::LIMIT_W-1:0]         daily_limit_i,
  input  wire logic [qmon_pkg::LIMIT_W-1:0]         monthly_limit_i,
  input  wire logic                                 out_stall_i,
  output logic                                      out_valid_o,
  output logic [qmon_pkg::CNT64_W-1:0]              day_rx_o,
  output logic [qmon_pkg::CNT64_W-1:0]              day_tx_o,
  output logic [qmon_pkg::CNT64_W-1:0]              month_rx_o,
  output logic [qmon_pkg::CNT64_W-1:0]              month_tx_o,
  output logic [qmon_pkg::CNT64_W-1:0]              alltime_rx_o,
  output logic [qmon_pkg::CNT64_W-1:0]              alltime_tx_o,
  output logic [1:0]                                daily_level_o,
  output logic [1:0]                                monthly_level_o,
  output logic                                      notify_daily_o,
  output logic                                      notify_monthly_o,
  output logic [1:0]                                prior_monthly_level_o
);

  localparam int IW = qmon_pkg::IDX_W;
  localparam int CW = qmon_pkg::CNT64_W;

  logic [qmon_pkg::KEY_W-1:0]   key_q;
  logic [qmon_pkg::DELTA_W-1:0] rxin_q, txin_q;
  logic [qmon_pkg::MONTH_W-1:0] month_q;
  logic [qmon_pkg::DAY_SLOTS-1:0] used_q;

  logic                         scan_v_q;
  logic [IW-1:0]                scan_idx_q;
  logic                         hit_q, free_q;
  logic [IW-1:0]                hit_idx_q, free_idx_q, min_idx_q;
  logic [CW-1:0]                hit_rx_q, hit_tx_q;
  logic [qmon_pkg::KEY_W-1:0]   min_key_q;

  logic [CW-1:0]                day_rx_q, day_tx_q;
  logic                         v1_q, v2_q;
  logic [IW-1:0]                idx1_q;
  logic [CW-1:0]                rx2_q, tx2_q;
  logic [qmon_pkg::MONTH_W-1:0] mo2_q;
  logic [CW-1:0]                arx_q, atx_q, mrx_q, mtx_q;
  logic [CW-1:0]                du_q, mu_q;
  logic [qmon_pkg::SCALE_W-1:0] dt_q, mt_q;
  qmon_pkg::level_e             dstate_q, mstate_q, dstate_d, mstate_d, d_lv, m_lv;
  logic                         nd, nm;
  logic                         out_valid_q;

  qmon_pkg::entry_t             rd_data, wr_data;
  logic [IW-1:0]                slot;
  logic [CW-1:0]                new_rx, new_tx;
  logic                         rd_used;

  qmon_ram #(
    .WIDTH ($bits(qmon_pkg::entry_t)),
    .DEPTH (qmon_pkg::DAY_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (slot),
    .wdata_i (wr_data),
    .raddr_i (cmd_i.addr),
    .rdata_o (rd_data)
  );

  assign rd_used = used_q[scan_idx_q];
  assign slot    = hit_q ? hit_idx_q : (free_q ? free_idx_q : min_idx_q);
  assign new_rx  = (hit_q ? hit_rx_q : '0) + CW'(rxin_q);
  assign new_tx  = (hit_q ? hit_tx_q : '0) + CW'(txin_q);
  assign wr_data = '{day: key_q, rx: new_rx, tx: new_tx};

  function automatic qmon_pkg::level_e grade(input logic [CW-1:0] u,
                                             input logic [qmon_pkg::SCALE_W-1:0] t,
                                             input logic [qmon_pkg::LIMIT_W-1:0] lim);
    qmon_pkg::level_e lv;
    if (u >= {8'd0, lim}) begin
      lv = qmon_pkg::LVL_OVER;
    end else if ({9'd0, lim, 3'd0} <= t) begin
      lv = qmon_pkg::LVL_NEAR;
    end else begin
      lv = qmon_pkg::LVL_NONE;
    end
    return lv;
  endfunction

  always_comb begin
    d_lv     = grade(du_q, dt_q, daily_limit_i);
    m_lv     = grade(mu_q, mt_q, monthly_limit_i);
    dstate_d = dstate_q;
    mstate_d = mstate_q;
    nd       = 1'b0;
    nm       = 1'b0;
    if ((daily_limit_i != '0) && (d_lv != dstate_q)) begin
      dstate_d = d_lv;
      nd       = (d_lv != qmon_pkg::LVL_NONE);
    end
    if ((monthly_limit_i != '0) && (m_lv != mstate_q)) begin
      mstate_d = m_lv;
      nm       = (m_lv != qmon_pkg::LVL_NONE);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      scan_v_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      dstate_q    <= qmon_pkg::LVL_NONE;
      mstate_q    <= qmon_pkg::LVL_NONE;
      out_valid_q <= 1'b0;
    end else begin
      scan_v_q <= cmd_i.scan_rd;
      v1_q     <= cmd_i.sum_rd;
      v2_q     <= v1_q && used_q[idx1_q];
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (scan_v_q) begin
        if (rd_used && (rd_data.day == key_q)) begin
          hit_q <= 1'b1;
        end
        if (!rd_used) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.write) begin
        used_q[slot] <= 1'b1;
      end
      if (cmd_i.grade_c) begin
        dstate_q    <= dstate_d;
        mstate_q    <= mstate_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    scan_idx_q <= cmd_i.addr;
    idx1_q     <= cmd_i.addr;
    if (cmd_i.load) begin
      key_q  <= day_key_i;
      rxin_q <= rx_bytes_i;
      txin_q <= tx_bytes_i;
      arx_q  <= '0;
      atx_q  <= '0;
      mrx_q  <= '0;
      mtx_q  <= '0;
    end
    if (cmd_i.scan_rd) begin
      month_q <= qmon_pkg::div100(key_q);
    end
    if (scan_v_q) begin
      if (rd_used && (rd_data.day == key_q)) begin
        hit_idx_q <= scan_idx_q;
        hit_rx_q  <= rd_data.rx;
        hit_tx_q  <= rd_data.tx;
      end
      if (!rd_used && !free_q) begin
        free_idx_q <= scan_idx_q;
      end
      if ((scan_idx_q == '0) || (rd_data.day < min_key_q)) begin
        min_key_q <= rd_data.day;
        min_idx_q <= scan_idx_q;
      end
    end
    if (cmd_i.write) begin
      day_rx_q <= new_rx;
      day_tx_q <= new_tx;
    end
    rx2_q <= rd_data.rx;
    tx2_q <= rd_data.tx;
    mo2_q <= qmon_pkg::div100(rd_data.day);
    if (v2_q) begin
      arx_q <= arx_q + rx2_q;
      atx_q <= atx_q + tx2_q;
      if (mo2_q == month_q) begin
        mrx_q <= mrx_q + rx2_q;
        mtx_q <= mtx_q + tx2_q;
      end
    end
    if (cmd_i.grade_a) begin
      du_q <= day_rx_q + day_tx_q;
      mu_q <= mrx_q + mtx_q;
    end
    if (cmd_i.grade_b) begin
      // 10*u + 9, so that 8*limit <= it matches u >= floor(8*limit/10)
      dt_q <= {1'b0, du_q, 3'd0} + {3'd0, du_q, 1'b0} + qmon_pkg::SCALE_W'(9);
      mt_q <= {1'b0, mu_q, 3'd0} + {3'd0, mu_q, 1'b0} + qmon_pkg::SCALE_W'(9);
    end
    if (cmd_i.grade_c) begin
      day_rx_o              <= day_rx_q;
      day_tx_o              <= day_tx_q;
      month_rx_o            <= mrx_q;
      month_tx_o            <= mtx_q;
      alltime_rx_o          <= arx_q;
      alltime_tx_o          <= atx_q;
      daily_level_o         <= dstate_d;
      monthly_level_o       <= mstate_d;
      notify_daily_o        <= nd;
      notify_monthly_o      <= nm;
      prior_monthly_level_o <= mstate_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  a_slot_marked_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |=> used_q[$past(slot)])
    else $error("written slot not marked used");

  a_notify_daily_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && notify_daily_o) |-> (daily_level_o != qmon_pkg::LVL_NONE))
    else $error("daily notify with no daily level");

  a_notify_monthly_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && notify_monthly_o) |-> (monthly_level_o != prior_monthly_level_o))
    else $error("monthly notify without a level change");

endmodule
`default_nettype wire

### rtl/daily_monthly_traffic_quota_monitor_core.sv
// daily_monthly_traffic_quota_monitor_core: top level with the register port
// depends on qmon_pkg, qmon_ctrl, qmon_dp (and qmon_ram below it)
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------------------------
//   in       | input     | in_valid_i / in_stall_o | day_key_i, rx_bytes_i, tx_bytes_i
//   out      | output    | out_valid_o/out_stall_i | day/month/alltime rx,tx, levels, notify
//   config   | input     | psel/penable/pready     | daily_limit at 0x0, monthly_limit at 0x8
//
// an item is handled in order: one pass over the day table to find the slot, one write,
// one pass to sum, then grading in GA, GB and GC; the table has a single read port
// reset clears all used bits and alert levels at once; the table needs no clearing pass
// the result waits in its own register; the next item is taken meanwhile and its grading
// stalls only while that register is still full
`timescale 1ns / 1ps
`default_nettype none
module daily_monthly_traffic_quota_monitor_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [qmon_pkg::KEY_W-1:0]    day_key_i,
  input  wire logic [qmon_pkg::DELTA_W-1:0]  rx_bytes_i,
  input  wire logic [qmon_pkg::DELTA_W-1:0]  tx_bytes_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [qmon_pkg::CNT64_W-1:0]       day_rx_o,
  output logic [qmon_pkg::CNT64_W-1:0]       day_tx_o,
  output logic [qmon_pkg::CNT64_W-1:0]       month_rx_o,
  output logic [qmon_pkg::CNT64_W-1:0]       month_tx_o,
  output logic [qmon_pkg::CNT64_W-1:0]       alltime_rx_o,
  output logic [qmon_pkg::CNT64_W-1:0]       alltime_tx_o,
  output logic [1:0]                         daily_level_o,
  output logic [1:0]                         monthly_level_o,
  output logic                               notify_daily_o,
  output logic                               notify_monthly_o,
  output logic [1:0]                         prior_monthly_level_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);

  logic [qmon_pkg::LIMIT_W-1:0] daily_limit_q, monthly_limit_q;
  qmon_pkg::cmd_t               cmd;
  qmon_pkg::sts_t               sts;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? {8'd0, monthly_limit_q} : {8'd0, daily_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      daily_limit_q   <= '0;
      monthly_limit_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        monthly_limit_q <= pwdata[qmon_pkg::LIMIT_W-1:0];
      end else begin
        daily_limit_q <= pwdata[qmon_pkg::LIMIT_W-1:0];
      end
    end
  end

  qmon_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qmon_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .day_key_i             (day_key_i),
    .rx_bytes_i            (rx_bytes_i),
    .tx_bytes_i            (tx_bytes_i),
    .daily_limit_i         (daily_limit_q),
    .monthly_limit_i       (monthly_limit_q),
    .out_stall_i           (out_stall_i),
    .out_valid_o           (out_valid_o),
    .day_rx_o              (day_rx_o),
    .day_tx_o              (day_tx_o),
    .month_rx_o            (month_rx_o),
    .month_tx_o            (month_tx_o),
    .alltime_rx_o          (alltime_rx_o),
    .alltime_tx_o          (alltime_tx_o),
    .daily_level_o         (daily_level_o),
    .monthly_level_o       (monthly_level_o),
    .notify_daily_o        (notify_daily_o),
    .notify_monthly_o      (notify_monthly_o),
    .prior_monthly_level_o (prior_monthly_level_o)
  );

endmodule
`default_nettype wire

### tb/daily_monthly_traffic_quota_monitor_core_tb.sv
// daily_monthly_traffic_quota_monitor_core_tb: self-checking bench for the quota monitor core
// predicts day/month/all-time totals and alert levels per item; depends on qmon_pkg and the rtl
`timescale 1ns / 1ps
module daily_monthly_traffic_quota_monitor_core_tb;

  localparam int DAY_SLOTS   = qmon_pkg::DAY_SLOTS;
  localparam int KEY_W       = qmon_pkg::KEY_W;
  localparam int DELTA_W     = qmon_pkg::DELTA_W;
  localparam int ITEM_CYCLES = 2 * DAY_SLOTS + 8;
  localparam int WATCHDOG    = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam logic [3:0] ADDR_DAILY   = 4'h0;
  localparam logic [3:0] ADDR_MONTHLY = 4'h8;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DELTA_W-1:0] rx;
    logic [DELTA_W-1:0] tx;
  } upd_t;

  typedef struct packed {
    logic [63:0] drx, dtx, mrx, mtx, arx, atx;
    logic [1:0]  dlv, mlv;
    logic        nd, nm;
    logic [1:0]  pml;
  } usage_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [KEY_W-1:0] day_key_i = '0;
  logic [DELTA_W-1:0] rx_bytes_i = '0, tx_bytes_i = '0;
  logic in_stall_o, out_valid_o;
  logic [63:0] day_rx_o, day_tx_o, month_rx_o, month_tx_o, alltime_rx_o, alltime_tx_o;
  logic [1:0] daily_level_o, monthly_level_o, prior_monthly_level_o;
  logic notify_daily_o, notify_monthly_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  logic pready;

  daily_monthly_traffic_quota_monitor_core uut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [KEY_W-1:0] p_day[DAY_SLOTS];
  logic [63:0] p_rx[DAY_SLOTS], p_tx[DAY_SLOTS];
  bit p_used[DAY_SLOTS];
  logic [1:0] p_dstate, p_mstate;
  logic [55:0] p_dlimit, p_mlimit;

  upd_t pending_q[$];
  usage_t expected_q[$];
  int mismatches = 0, results = 0, idle_cnt = 0;
  bit quiet = 0, hold_rx = 0, timed_out = 0;
  int in_gap = 0, out_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;

  function automatic logic [1:0] grade_usage(logic [63:0] used, logic [55:0] lim);
    logic [63:0] l;
    l = {8'd0, lim};
    if (used >= l) return qmon_pkg::LVL_OVER;
    if (used >= l * 8 / 10) return qmon_pkg::LVL_NEAR;
    return qmon_pkg::LVL_NONE;
  endfunction

  function automatic usage_t predict_usage(upd_t u);
    usage_t r;
    int s, i;
    logic [63:0] tot;
    s = -1;
    r = '0;
    r.pml = p_mstate;
    for (i = 0; i < DAY_SLOTS; i++) if (s < 0 && p_used[i] && p_day[i] == u.key) s = i;
    if (s < 0) begin
      for (i = 0; i < DAY_SLOTS; i++) if (s < 0 && !p_used[i]) s = i;
      if (s < 0) begin
        s = 0;
        for (i = 1; i < DAY_SLOTS; i++) if (p_day[i] < p_day[s]) s = i;
      end
      p_used[s] = 1; p_day[s] = u.key; p_rx[s] = 0; p_tx[s] = 0;
    end
    p_rx[s] += u.rx;
    p_tx[s] += u.tx;
    for (i = 0; i < DAY_SLOTS; i++) if (p_used[i]) begin
      r.arx += p_rx[i]; r.atx += p_tx[i];
      if (p_day[i] / 100 == u.key / 100) begin
        r.mrx += p_rx[i]; r.mtx += p_tx[i];
      end
    end
    if (p_dlimit != 0) begin
      tot = p_rx[s] + p_tx[s];
      if (grade_usage(tot, p_dlimit) != p_dstate) begin
        p_dstate = grade_usage(tot, p_dlimit);
        r.nd = (p_dstate != qmon_pkg::LVL_NONE);
      end
    end
    if (p_mlimit != 0) begin
      tot = r.mrx + r.mtx;
      if (grade_usage(tot, p_mlimit) != p_mstate) begin
        p_mstate = grade_usage(tot, p_mlimit);
        r.nm = (p_mstate != qmon_pkg::LVL_NONE);
      end
    end
    r.drx = p_rx[s]; r.dtx = p_tx[s];
    r.dlv = p_dstate; r.mlv = p_mstate;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i)
          expected_q = {expected_q, predict_usage({day_key_i, rx_bytes_i, tx_bytes_i})};
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 0;
        end else if (pending_q.size() > 0) begin
          {day_key_i, rx_bytes_i, tx_bytes_i} <= pending_q.pop_front();
          in_valid_i <= 1;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 5);
        end else in_valid_i <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    usage_t e, a;
    if (rst_ni) begin
      idle_cnt <= ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) ?
                  0 : idle_cnt + 1;
      if (out_valid_o && !out_stall_i) begin
        a = {day_rx_o, day_tx_o, month_rx_o, month_tx_o, alltime_rx_o, alltime_tx_o,
             daily_level_o, monthly_level_o, notify_daily_o, notify_monthly_o,
             prior_monthly_level_o};
        results <= results + 1;
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected item %h", a);
        end else begin
          e = expected_q.pop_front();
          if (e !== a) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp %h %h %h %h %h %h %0d %0d %b %b %0d",
                       e.drx, e.dtx, e.mrx, e.mtx, e.arx, e.atx, e.dlv, e.mlv, e.nd, e.nm,
                       e.pml, "\n          got %h %h %h %h %h %h %0d %0d %b %b %0d",
                       a.drx, a.dtx, a.mrx, a.mtx, a.arx, a.atx, a.dlv, a.mlv, a.nd, a.nm,
                       a.pml);
          end
        end
      end
      if (hold_rx && !hold_done) begin
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1;
        out_stall_i <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= 0;
        if (!quiet && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("daily_monthly_traffic_quota_monitor_core: mismatch");
      $finish;
    end
  end

  task automatic enqueue(upd_t u);
    pending_q = {pending_q, u};
  endtask

  task automatic write_limit(logic [3:0] addr, logic [55:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= {8'd0, val};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_DAILY) p_dlimit = val; else p_mlimit = val;
  endtask

  task automatic drain_all();
    wait (pending_q.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (ITEM_CYCLES + 10) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] rand_date(int month_base);
    return KEY_W'(month_base * 100 + $urandom_range(1, 31));
  endfunction

  function automatic logic [DELTA_W-1:0] rand_delta();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return $urandom;
      default: return $urandom_range(0, 200000);
    endcase
  endfunction

  task automatic add_random(int n);
    int month;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) month = $urandom_range(0, 999999);
      else month = 202400 + $urandom_range(1, 3);
      if ($urandom_range(0, 29) == 0)
        enqueue({KEY_W'($urandom_range(0, (1 << KEY_W) - 1)), rand_delta(), rand_delta()});
      else enqueue({rand_date(month), rand_delta(), rand_delta()});
    end
  endtask

  initial begin
    p_used = '{default: 0};
    p_dstate = qmon_pkg::LVL_NONE; p_mstate = qmon_pkg::LVL_NONE;
    p_dlimit = 0; p_mlimit = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    // directed: disabled limits, extremes, key extremes, then daily near and over crossings and an older date
    enqueue({27'd0, 32'd0, 32'd0});
    enqueue({27'h7ffffff, 32'hffffffff, 32'hffffffff});
    enqueue({27'd99991231, 32'hffffffff, 32'd0});
    enqueue({27'd20240101, 32'd5, 32'd7});
    drain_all();
    write_limit(ADDR_DAILY, 56'd1000);
    write_limit(ADDR_MONTHLY, 56'd3000);
    enqueue({27'd20240102, 32'd100, 32'd100});
    enqueue({27'd20240102, 32'd400, 32'd200});
    enqueue({27'd20240102, 32'd200, 32'd0});
    enqueue({27'd20240103, 32'd1000, 32'd600});
    enqueue({27'd20240103, 32'd0, 32'd0});
    for (int d = 0; d < 12; d++) enqueue({27'(20240210 + d), 32'd1, 32'd1});
    enqueue({27'd1, 32'd3, 32'd4});
    drain_all();
    write_limit(ADDR_DAILY, 56'hffffffffffffff);
    write_limit(ADDR_MONTHLY, 56'd1);
    add_random(300);
    drain_all();
    // long receiver hold-off while the sender keeps offering
    hold_rx = 1;
    add_random(50);
    wait (hold_done && hold_left == 0);
    hold_rx = 0;
    drain_all();
    write_limit(ADDR_DAILY, 56'd3000000);
    write_limit(ADDR_MONTHLY, 56'd40000000);
    add_random(500);
    drain_all();
    write_limit(ADDR_DAILY, 56'd0);
    write_limit(ADDR_MONTHLY, 56'd8000000000);
    add_random(350);
    drain_all();
    quiet = 1;
    write_limit(ADDR_DAILY, 56'd9000000000);
    add_random(330);
    drain_all();
    $display("covered %0d results over five limit settings with table eviction and hold-off",
             results);
    if (mismatches == 0) $display("daily_monthly_traffic_quota_monitor_core: match");
    else $display("daily_monthly_traffic_quota_monitor_core: mismatch");
    $finish;
  end
endmodule
